>>> rtl/kalman_angle_bias_filter_assert.svh
// assertion macros for the tilt filter
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH

// implication checked every cycle outside reset
`define KABF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define KABF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/kabf_pkg.sv
package kabf_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned NoiseW = 31;
	localparam int unsigned DtW = 20;
	localparam int unsigned RegIdxW = 2;

	localparam logic [RegIdxW-1:0] REG_ANGLE_Q = 2'd0;
	localparam logic [RegIdxW-1:0] REG_BIAS_Q = 2'd1;
	localparam logic [RegIdxW-1:0] REG_MEAS_R = 2'd2;

	localparam logic [NoiseW-1:0] ANGLE_Q_RST = 31'd1073742;
	localparam logic [NoiseW-1:0] BIAS_Q_RST = 31'd3221225;
	localparam logic [NoiseW-1:0] MEAS_R_RST = 31'd32212255;
	localparam logic signed [DataW-1:0] ONE_Q30 = 32'sd1073741824;

	// sequencer steps
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_ANG,   // dt*(rate-bias)
		ST_P_T,     // t = dt*cbb
		ST_P_CAA,   // dt*(t-cab-cba+qa)
		ST_P_CBB,   // qb*dt, cab/cba -= t
		ST_S,       // y, and the sign test of S
		ST_DIV0,
		ST_DIV1,
		ST_U_ANG,
		ST_U_BIAS,
		ST_U_CAA,
		ST_U_CAB,
		ST_U_CBA,
		ST_U_CBB,
		ST_OUT
	} state_t;

	// operand request to the shared multiplier
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [33:0] b;
		logic [5:0] shift;
	} mul_req_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [73:0] x);
		if (x > 74'sd2147483647) return 32'sh7fffffff;
		if (x < -74'sd2147483648) return 32'sh80000000;
		return x[DataW-1:0];
	endfunction

endpackage

>>> rtl/kabf_mul.sv
// shared multiplier with round half up and arithmetic shift, registered result
module kabf_mul import kabf_pkg::*; (
	input  logic clk,
	input  kabf_pkg::mul_req_t req,
	output logic signed [73:0] prod_q
);
	logic signed [65:0] m;
	logic signed [73:0] half;
	logic signed [73:0] p;

	// product plus half lsb, then floor shift
	always_comb begin
		m = 66'(req.a) * 66'(req.b);
		half = 74'(1) <<< (req.shift - 6'd1);
		p = (74'(m) + half) >>> req.shift;
	end

	always_ff @(posedge clk) begin
		prod_q <= p;
	end
endmodule

>>> rtl/kabf_div.sv
// restoring divider, one quotient bit per cycle: num*2^30/den, num >= 0, den > 0
module kabf_div import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] num,
	input  logic [32:0] den,
	output logic done,
	output logic [61:0] quo_q
);
	logic [33:0] rem_q;
	logic [61:0] dvd_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [34:0] trial;

	assign trial = {rem_q, dvd_q[61]} - {2'b0, den};
	// all 62 quotient bits are in place once the count runs out
	assign done = busy_q && cnt_q == 6'd0;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd62;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	// shift one dividend bit in per cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {num, 30'd0};
			quo_q <= '0;
		end else if (busy_q && !done) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[60:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[61]};
				quo_q <= {quo_q[60:0], 1'b0};
			end
			dvd_q <= {dvd_q[60:0], 1'b0};
		end
	end
endmodule

>>> rtl/kalman_angle_bias_filter.sv
// channel  | dir | contents
// s_axis   | in  | tdata: measured_angle, gyro_rate, step_time (84 bits in 88)
// m_axis   | out | tdata: filtered_angle (32 bits)
// cfg      | in  | cfg_we, cfg_index, cfg_data (31 bits)
// a request runs four predict passes through the shared multiplier, a step for y and
// the test of S, two gain divisions, six update passes and a step to load the result;
// the divisions are skipped when the innovation variance is not positive.
// reset (arst_n low) restores noise defaults, zero estimates and unit covariance.
// s_axis_tready is high only while idle; a result still held in the output register
// stalls the sequencer at its last step until m_axis_tready.
module kalman_angle_bias_filter import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [87:0] s_axis_tdata, // measured_angle, gyro_rate, step_time, pad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // filtered_angle
	input  logic cfg_we,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [NoiseW-1:0] cfg_data
);
	`include "kalman_angle_bias_filter_assert.svh"

	state_t state_q, state_d;
	logic [NoiseW-1:0] qa_q, qb_q, r_q;
	logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	logic signed [31:0] meas_q, rate_q, t_q, y_q, k0_q, k1_q, caa0_q, cab0_q;
	logic [DtW-1:0] dt_q;
	logic signed [33:0] s_q;
	logic phase_q;
	logic [31:0] out_q;
	logic outv_q;
	logic out_load;
	mul_req_t req;
	logic signed [73:0] prod_q;
	logic div_start, div_done;
	logic [31:0] div_num;
	logic [61:0] quo_q;
	logic num_neg;
	logic signed [31:0] k_sat;
	logic signed [33:0] caa_sum;

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata = out_q;
	assign out_load = state_q == ST_OUT && (!outv_q || m_axis_tready);

	kabf_mul u_mul (.clk(clk), .req(req), .prod_q(prod_q));

	// gain divider operand: magnitude of caa or cba
	always_comb begin
		logic signed [32:0] n;
		n = (state_q == ST_DIV0) ? 33'(caa_q) : 33'(cba_q);
		num_neg = n < 0;
		div_num = num_neg ? 32'(-n) : 32'(n);
	end
	assign div_start = (state_q == ST_DIV0 || state_q == ST_DIV1) && !phase_q;

	kabf_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(s_q[32:0]), .done(div_done), .quo_q(quo_q));

	// saturate quotient to gain
	always_comb begin
		k_sat = '0;
		if (num_neg) begin
			if (quo_q > 62'd2147483648) k_sat = 32'sh80000000;
			else k_sat = 32'(-$signed({1'b0, quo_q[31:0]}));
		end else begin
			if (quo_q > 62'd2147483647) k_sat = 32'sh7fffffff;
			else k_sat = quo_q[31:0];
		end
	end

	// caa prediction sum, needs 34 bits
	assign caa_sum = 34'(t_q) - 34'(cab_q) - 34'(cba_q) + 34'($signed({1'b0, qa_q}));

	// multiplier operand selection
	always_comb begin
		req = '{a: '0, b: '0, shift: 6'd20};
		case (state_q)
			ST_P_ANG: req = '{a: 32'($signed({1'b0, dt_q})),
				b: 34'(rate_q) - 34'(bias_q), shift: 6'd20};
			ST_P_T:   req = '{a: 32'($signed({1'b0, dt_q})), b: 34'(cbb_q), shift: 6'd20};
			ST_P_CAA: req = '{a: 32'($signed({1'b0, dt_q})), b: caa_sum, shift: 6'd20};
			ST_P_CBB: req = '{a: 32'($signed({1'b0, dt_q})),
				b: 34'($signed({1'b0, qb_q})), shift: 6'd20};
			ST_U_ANG:  req = '{a: k0_q, b: 34'(y_q), shift: 6'd30};
			ST_U_BIAS: req = '{a: k1_q, b: 34'(y_q), shift: 6'd30};
			ST_U_CAA:  req = '{a: k0_q, b: 34'(caa0_q), shift: 6'd30};
			ST_U_CAB:  req = '{a: k0_q, b: 34'(cab0_q), shift: 6'd30};
			ST_U_CBA:  req = '{a: k1_q, b: 34'(caa0_q), shift: 6'd30};
			ST_U_CBB:  req = '{a: k1_q, b: 34'(cab0_q), shift: 6'd30};
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_P_ANG;
			ST_P_ANG: if (phase_q) state_d = ST_P_T;
			ST_P_T: if (phase_q) state_d = ST_P_CAA;
			ST_P_CAA: if (phase_q) state_d = ST_P_CBB;
			ST_P_CBB: if (phase_q) state_d = ST_S;
			ST_S: state_d = (s_q > 0) ? ST_DIV0 : ST_U_ANG;
			ST_DIV0: if (div_done) state_d = ST_DIV1;
			ST_DIV1: if (div_done) state_d = ST_U_ANG;
			ST_U_ANG: if (phase_q) state_d = ST_U_BIAS;
			ST_U_BIAS: if (phase_q) state_d = ST_U_CAA;
			ST_U_CAA: if (phase_q) state_d = ST_U_CAB;
			ST_U_CAB: if (phase_q) state_d = ST_U_CBA;
			ST_U_CBA: if (phase_q) state_d = ST_U_CBB;
			ST_U_CBB: if (phase_q) state_d = ST_OUT;
			ST_OUT: if (!outv_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer, state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			outv_q <= 1'b0;
			qa_q <= ANGLE_Q_RST;
			qb_q <= BIAS_Q_RST;
			r_q <= MEAS_R_RST;
			ang_q <= '0;
			bias_q <= '0;
			caa_q <= ONE_Q30;
			cab_q <= '0;
			cba_q <= '0;
			cbb_q <= ONE_Q30;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_Q: qa_q <= cfg_data;
					REG_BIAS_Q: qb_q <= cfg_data;
					REG_MEAS_R: r_q <= cfg_data;
					default: ;
				endcase
			end
			outv_q <= out_load || (outv_q && !m_axis_tready);
			if (state_q != state_d) phase_q <= 1'b0;
			else if (state_q != ST_IDLE) phase_q <= 1'b1;
			if (phase_q && state_q != state_d) begin
				case (state_q)
					ST_P_ANG: ang_q <= sat32(74'(ang_q) + prod_q);
					ST_P_T: t_q <= sat32(prod_q);
					ST_P_CAA: caa_q <= sat32(74'(caa_q) + prod_q);
					ST_P_CBB: begin
						cab_q <= sat32(74'(cab_q) - 74'(t_q));
						cba_q <= sat32(74'(cba_q) - 74'(t_q));
						cbb_q <= sat32(74'(cbb_q) + prod_q);
					end
					ST_U_ANG: ang_q <= sat32(74'(ang_q) + prod_q);
					ST_U_BIAS: bias_q <= sat32(74'(bias_q) + prod_q);
					ST_U_CAA: caa_q <= sat32(74'(caa_q) - prod_q);
					ST_U_CAB: cab_q <= sat32(74'(cab_q) - prod_q);
					ST_U_CBA: cba_q <= sat32(74'(cba_q) - prod_q);
					ST_U_CBB: cbb_q <= sat32(74'(cbb_q) - prod_q);
					default: ;
				endcase
			end
		end
	end

	// item operands, innovation, gains and result data
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			meas_q <= s_axis_tdata[31:0];
			rate_q <= s_axis_tdata[63:32];
			dt_q <= s_axis_tdata[83:64];
		end
		if (state_q == ST_S) begin
			y_q <= sat32(74'(meas_q) - 74'(ang_q));
			caa0_q <= caa_q;
			cab0_q <= cab_q;
			k0_q <= '0;
			k1_q <= '0;
		end
		if (state_q == ST_P_CBB)
			s_q <= 34'(caa_q) + 34'($signed({1'b0, r_q}));
		if (state_q == ST_DIV0 && div_done) k0_q <= k_sat;
		if (state_q == ST_DIV1 && div_done) k1_q <= k_sat;
		if (out_load) out_q <= ang_q;
	end

	`KABF_ASSERT_IMPL(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready)
	`KABF_ASSERT_NEXT(a_out_sets_valid, state_q == ST_OUT, m_axis_tvalid)
	`KABF_ASSERT_NEXT(a_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

>>> tb/kalman_angle_bias_filter_checker.sv
`timescale 1ns / 100ps

// watches the stream and configuration ports, predicts each filtered angle
// and compares it with what the filter returns
module kalman_angle_bias_filter_checker import kabf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [87:0] s_axis_tdata, // measured_angle, gyro_rate, step_time, pad
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [31:0] m_axis_tdata, // filtered_angle
	input  logic cfg_we,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [NoiseW-1:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;

	// filter model state
	longint q_angle, q_bias, r_meas;
	longint est_angle, est_bias;
	longint p_aa, p_ab, p_ba, p_bb;

	logic signed [31:0] angle_queue[$];

	function automatic longint rnd_shr(input longint x, input int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(input longint x);
		if (x > I32_MAX) return I32_MAX;
		if (x < I32_MIN) return I32_MIN;
		return x;
	endfunction

	// num * 2^30 / den, toward zero, saturated
	function automatic longint gain_div(input longint num, input longint den);
		longint mag;
		longint quo;
		mag = (num < 0) ? -num : num;
		quo = (mag <<< 30) / den;
		if (num < 0) return (quo > (64'sd1 <<< 31)) ? I32_MIN : -quo;
		return (quo > I32_MAX) ? I32_MAX : quo;
	endfunction

	// one predict and correct step; returns the new angle
	function automatic logic signed [31:0] kalman_step(input logic [87:0] req);
		longint meas, rate, dt, t, y, s, k0, k1, caa, cab;
		meas = longint'($signed(req[31:0]));
		rate = longint'($signed(req[63:32]));
		dt = longint'(req[83:64]);
		k0 = 0;
		k1 = 0;
		est_angle = clamp32(est_angle + rnd_shr(dt * (rate - est_bias), 20));
		t = rnd_shr(dt * p_bb, 20);
		p_aa = clamp32(p_aa + rnd_shr(dt * (t - p_ab - p_ba + q_angle), 20));
		p_ab = clamp32(p_ab - t);
		p_ba = clamp32(p_ba - t);
		p_bb = clamp32(p_bb + rnd_shr(q_bias * dt, 20));
		y = clamp32(meas - est_angle);
		s = p_aa + r_meas;
		if (s > 0) begin
			k0 = gain_div(p_aa, s);
			k1 = gain_div(p_ba, s);
		end
		est_angle = clamp32(est_angle + rnd_shr(k0 * y, 30));
		est_bias = clamp32(est_bias + rnd_shr(k1 * y, 30));
		caa = p_aa;
		cab = p_ab;
		p_aa = clamp32(p_aa - rnd_shr(k0 * caa, 30));
		p_ab = clamp32(p_ab - rnd_shr(k0 * cab, 30));
		p_ba = clamp32(p_ba - rnd_shr(k1 * caa, 30));
		p_bb = clamp32(p_bb - rnd_shr(k1 * cab, 30));
		return est_angle[31:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	assign pending = angle_queue.size();

	// track configuration, requests and results
	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		if (!arst_n) begin
			q_angle = ANGLE_Q_RST;
			q_bias = BIAS_Q_RST;
			r_meas = MEAS_R_RST;
			est_angle = 0;
			est_bias = 0;
			p_aa = ONE_Q30;
			p_ab = 0;
			p_ba = 0;
			p_bb = ONE_Q30;
			angle_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_Q: q_angle = cfg_data;
					REG_BIAS_Q: q_bias = cfg_data;
					REG_MEAS_R: r_meas = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (angle_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					want = angle_queue.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("filtered_angle %h, expected %h",
							m_axis_tdata, want));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				angle_queue.push_back(kalman_step(s_axis_tdata));
		end
	end

	initial fail_count = 0;

endmodule

>>> tb/kalman_angle_bias_filter_tb.sv
`timescale 1ns / 100ps

module kalman_angle_bias_filter_tb import kabf_pkg::*; ();

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 165;
	// index with no register behind it
	localparam logic [RegIdxW-1:0] REG_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata; // measured_angle, gyro_rate, step_time, pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata; // filtered_angle
	logic cfg_we;
	logic [RegIdxW-1:0] cfg_index;
	logic [NoiseW-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned pending;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	longint cycle_count;

	kalman_angle_bias_filter dut (.*);

	kalman_angle_bias_filter_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout");
				$display("FAIL");
				$finish;
			end
		end
	end

	// result side ready, with random stalls and long hold-offs
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [NoiseW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain_results();
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_sample(input logic [31:0] meas, input logic [31:0] rate,
		input logic [19:0] dt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {4'd0, dt, rate, meas};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// mostly a steady tilt with small rates, sometimes full-range noise
	task automatic send_random();
		logic [31:0] meas, rate;
		logic [19:0] dt;
		if ($urandom_range(99) < 75) begin
			meas = $urandom_range(0, 32'h00b4_0000) - 32'h005a_0000;
			rate = $urandom_range(0, 32'h01f4_0000) - 32'h00fa_0000;
			dt = 20'($urandom_range(200, 20000));
		end else begin
			meas = $urandom();
			rate = $urandom();
			dt = 20'($urandom());
		end
		send_sample(meas, rate, dt);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ANGLE_Q;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and large innovations at reset settings
		send_sample(32'h0000_0000, 32'h0000_0000, 20'd0);
		send_sample(32'h7fff_ffff, 32'h0000_0000, 20'd0);
		send_sample(32'h8000_0000, 32'h7fff_ffff, 20'hfffff);
		send_sample(32'h7fff_ffff, 32'h8000_0000, 20'hfffff);
		send_sample(32'h8000_0000, 32'h8000_0000, 20'd1);
		send_sample(32'h0001_0000, 32'h0000_0000, 20'd1049);
		send_sample(32'hffff_0000, 32'h7fff_ffff, 20'hfffff);
		send_sample(32'h7fff_ffff, 32'h7fff_ffff, 20'hfffff);
		drain_results();
		// zero process noise, smallest measurement noise, unused index ignored
		write_reg(REG_ANGLE_Q, '0);
		write_reg(REG_BIAS_Q, '0);
		write_reg(REG_MEAS_R, 31'd1);
		write_reg(REG_NONE, 31'h7fff_ffff);
		send_sample(32'h0000_0000, 32'h0000_0000, 20'd0);
		send_sample(32'h8000_0000, 32'h8000_0000, 20'hfffff);
		send_sample(32'h7fff_ffff, 32'h0000_0000, 20'h80000);
		send_sample(32'h1234_5678, 32'h8765_4321, 20'h0ffff);
		drain_results();
		// largest noise everywhere
		write_reg(REG_ANGLE_Q, 31'h7fff_ffff);
		write_reg(REG_BIAS_Q, 31'h7fff_ffff);
		write_reg(REG_MEAS_R, 31'h7fff_ffff);
		send_sample(32'h7fff_ffff, 32'h8000_0000, 20'hfffff);
		send_sample(32'h8000_0000, 32'h7fff_ffff, 20'hfffff);
		send_sample(32'h0000_0000, 32'h0000_0000, 20'd0);
		send_sample(32'h0040_0000, 32'hffc0_0000, 20'h00400);

		// random phases under different idling
		for (phase = 0; phase < 5; phase++) begin
			drain_results();
			case (phase)
				0: begin
					write_reg(REG_ANGLE_Q, ANGLE_Q_RST);
					write_reg(REG_BIAS_Q, BIAS_Q_RST);
					write_reg(REG_MEAS_R, MEAS_R_RST);
				end
				1: write_reg(REG_MEAS_R, 31'd1);
				2: begin
					write_reg(REG_ANGLE_Q, 31'($urandom()));
					write_reg(REG_BIAS_Q, 31'($urandom()));
					write_reg(REG_MEAS_R, 31'($urandom_range(1, 32'h7fff_ffff)));
				end
				3: write_reg(REG_MEAS_R, 31'h7fff_ffff);
				default: begin
					write_reg(REG_ANGLE_Q, 31'($urandom_range(0, 4000000)));
					write_reg(REG_BIAS_Q, 31'($urandom_range(0, 8000000)));
					write_reg(REG_MEAS_R, 31'($urandom_range(1, 80000000)));
				end
			endcase
			send_idle_pct = (phase == 1 || phase == 4) ? 70 : (phase == 3 ? 32 : 0);
			recv_stall_pct = (phase == 2 || phase == 4) ? 70 : (phase == 3 ? 32 : 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while requests keep coming
				if (phase == 0 && n == 40) hold_cycles = 600;
				// sender waits for every result once
				if (phase == 0 && n == 80)
					while (pending != 0) @(posedge clk);
				send_random();
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
